[rtl/afe_pkg.sv]
// Shared types and constants for the API transmit frame encoder.
package afe_pkg;

   localparam logic [7:0] MAX_SIZE  = 8'd244;
   localparam logic [7:0] LEN_EXTRA = 8'd11;
   localparam logic [7:0] SUM_BASE  = 8'hFF;
   localparam logic [7:0] ZERO_BYTE = 8'h00;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEST_ADDRESS = 3'd0,
      CSR_DELIMITER    = 3'd1,
      CSR_ESCAPE       = 3'd2,
      CSR_XON          = 3'd3,
      CSR_XOFF         = 3'd4,
      CSR_XOR_MASK     = 3'd5,
      CSR_REQUEST_TYPE = 3'd6
   } csr_index_type;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   typedef enum logic [3:0] {
      SLOT_DONE,
      SLOT_DELIM,
      SLOT_ZERO,
      SLOT_LEN,
      SLOT_TYPE,
      SLOT_FID,
      SLOT_ADDR,
      SLOT_OPT,
      SLOT_DATA,
      SLOT_SUM,
      SLOT_ERR
   } slot_type;

   typedef struct packed {
      logic [63:0] dest_address;
      logic [7:0]  delimiter_byte;
      logic [7:0]  escape_byte;
      logic [7:0]  xon_byte;
      logic [7:0]  xoff_byte;
      logic [7:0]  xor_mask;
      logic [7:0]  request_type;
   } cfg_type;

   typedef struct packed {
      logic       func;
      logic [7:0] payload_size;
      logic [7:0] frame_id;
      logic [7:0] options;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_done;
      logic       error;
   } result_type;

endpackage

[rtl/afe_cfg.sv]
// Configuration register file of the frame encoder.
module afe_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [afe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [63:0]                    csr_wdata,
   output logic                           csr_ready,
   output afe_pkg::cfg_type               cfg
);
   import afe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEST_ADDRESS: cfg_in.dest_address   = csr_wdata;
            CSR_DELIMITER:    cfg_in.delimiter_byte = csr_wdata[7:0];
            CSR_ESCAPE:       cfg_in.escape_byte    = csr_wdata[7:0];
            CSR_XON:          cfg_in.xon_byte       = csr_wdata[7:0];
            CSR_XOFF:         cfg_in.xoff_byte      = csr_wdata[7:0];
            CSR_XOR_MASK:     cfg_in.xor_mask       = csr_wdata[7:0];
            CSR_REQUEST_TYPE: cfg_in.request_type   = csr_wdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_address   <= 64'd0;
         cfg_ff.delimiter_byte <= 8'h7E;
         cfg_ff.escape_byte    <= 8'h7D;
         cfg_ff.xon_byte       <= 8'h11;
         cfg_ff.xoff_byte      <= 8'h13;
         cfg_ff.xor_mask       <= 8'h20;
         cfg_ff.request_type   <= 8'h00;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/afe_seq.sv]
// Byte sequencer: walks the frame slots of one transaction, escapes and sums bytes.
module afe_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  afe_pkg::cfg_type     cfg,
   input  afe_pkg::item_type    item,
   input  logic                 load,
   input  logic                 step,
   output afe_pkg::result_type  result,
   output logic                 item_done
);
   import afe_pkg::*;

   slot_type   slot_ff, slot_in;
   logic       phase_ff, phase_in;
   logic [2:0] addr_idx_ff, addr_idx_in;
   logic       fresh_ff, fresh_in;
   logic       frame_open_ff, frame_open_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] sum_ff, sum_in;

   slot_type   cur_slot;
   slot_type   next_slot;
   logic [7:0] size_clamped;
   logic [7:0] left_dec;
   logic [7:0] raw_byte;
   logic [2:0] byte_sel;
   logic       escapable;
   logic       special;
   logic       need_esc;
   logic       byte_done;

   assign size_clamped = (item.payload_size > MAX_SIZE) ? MAX_SIZE : item.payload_size;
   assign left_dec     = bytes_left_ff - 8'd1;
   assign byte_sel     = ~addr_idx_ff;

   // Pick the opening slot from the frame state left by the previous transaction
   always_comb begin
      if (fresh_ff) begin
         if (item.func == FUNC_START) begin
            cur_slot = SLOT_DELIM;
         end else if (frame_open_ff) begin
            cur_slot = SLOT_DATA;
         end else begin
            cur_slot = SLOT_ERR;
         end
      end else begin
         cur_slot = slot_ff;
      end
   end

   // Output logic
   always_comb begin
      unique case (cur_slot)
         SLOT_DELIM: raw_byte = cfg.delimiter_byte;
         SLOT_LEN:   raw_byte = size_clamped + LEN_EXTRA;
         SLOT_TYPE:  raw_byte = cfg.request_type;
         SLOT_FID:   raw_byte = item.frame_id;
         SLOT_ADDR:  raw_byte = cfg.dest_address[{byte_sel, 3'b000} +: 8];
         SLOT_OPT:   raw_byte = item.options;
         SLOT_DATA:  raw_byte = item.data_byte;
         SLOT_SUM:   raw_byte = SUM_BASE - sum_ff;
         default:    raw_byte = ZERO_BYTE;
      endcase

      escapable = (cur_slot != SLOT_DELIM) && (cur_slot != SLOT_ZERO) &&
                  (cur_slot != SLOT_ERR) && (cur_slot != SLOT_DONE);
      special   = (raw_byte == cfg.delimiter_byte) || (raw_byte == cfg.escape_byte) ||
                  (raw_byte == cfg.xon_byte) || (raw_byte == cfg.xoff_byte);
      need_esc  = escapable && special;
      byte_done = !need_esc || phase_ff;

      if (need_esc && !phase_ff) begin
         result.out_byte = cfg.escape_byte;
      end else if (need_esc) begin
         result.out_byte = raw_byte ^ cfg.xor_mask;
      end else begin
         result.out_byte = raw_byte;
      end

      item_done         = byte_done && (next_slot == SLOT_DONE);
      result.run_last   = item_done;
      result.frame_done = byte_done && (cur_slot == SLOT_SUM);
      result.error      = (cur_slot == SLOT_ERR);
   end

   // Next-state logic
   always_comb begin
      unique case (cur_slot)
         SLOT_DELIM: next_slot = SLOT_ZERO;
         SLOT_ZERO:  next_slot = SLOT_LEN;
         SLOT_LEN:   next_slot = SLOT_TYPE;
         SLOT_TYPE:  next_slot = SLOT_FID;
         SLOT_FID:   next_slot = SLOT_ADDR;
         SLOT_ADDR:  next_slot = (addr_idx_ff == 3'd7) ? SLOT_OPT : SLOT_ADDR;
         SLOT_OPT:   next_slot = (size_clamped == ZERO_BYTE) ? SLOT_SUM : SLOT_DONE;
         SLOT_DATA:  next_slot = (left_dec == ZERO_BYTE) ? SLOT_SUM : SLOT_DONE;
         default:    next_slot = SLOT_DONE;
      endcase

      slot_in       = slot_ff;
      phase_in      = phase_ff;
      addr_idx_in   = addr_idx_ff;
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      sum_in        = sum_ff;
      fresh_in      = fresh_ff;

      if (step) begin
         fresh_in = 1'b0;
         if (byte_done) begin
            slot_in     = next_slot;
            phase_in    = 1'b0;
            addr_idx_in = (cur_slot == SLOT_ADDR) ? addr_idx_ff + 3'd1 : 3'd0;
            unique case (cur_slot)
               SLOT_DELIM: sum_in = ZERO_BYTE;
               SLOT_TYPE, SLOT_FID, SLOT_ADDR: sum_in = sum_ff + raw_byte;
               SLOT_OPT: begin
                  sum_in        = sum_ff + raw_byte;
                  bytes_left_in = size_clamped;
                  frame_open_in = 1'b1;
               end
               SLOT_DATA: begin
                  sum_in        = sum_ff + raw_byte;
                  bytes_left_in = left_dec;
               end
               SLOT_SUM: begin
                  sum_in        = ZERO_BYTE;
                  bytes_left_in = ZERO_BYTE;
                  frame_open_in = 1'b0;
               end
               default: sum_in = sum_ff;
            endcase
         end else begin
            // hold the slot and send the masked byte next
            slot_in  = cur_slot;
            phase_in = 1'b1;
         end
      end

      if (load) begin
         fresh_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= SLOT_DONE;
         phase_ff      <= 1'b0;
         addr_idx_ff   <= 3'd0;
         fresh_ff      <= 1'b0;
         frame_open_ff <= 1'b0;
         bytes_left_ff <= ZERO_BYTE;
         sum_ff        <= ZERO_BYTE;
      end else begin
         slot_ff       <= slot_in;
         phase_ff      <= phase_in;
         addr_idx_ff   <= addr_idx_in;
         fresh_ff      <= fresh_in;
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
         sum_ff        <= sum_in;
      end
   end

endmodule

[rtl/api_tx_frame_encoder_unit.sv]
// The first line byte of a transaction passes the item register and then the rsp register.
// Throughput: one line byte per cycle while rsp is not stalled, set by the byte sequencer;
// a start transaction gives 14 to 28 line bytes, a data transaction 1 to 4.
// A new transaction is taken in the cycle the previous one hands over its last byte.
// Synchronous active-high reset clears the frame state and loads register defaults.
module api_tx_frame_encoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [7:0]                    req_payload_size,
   input  logic [7:0]                    req_frame_id,
   input  logic [7:0]                    req_options,
   input  logic [7:0]                    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_run_last,
   output logic                          rsp_frame_done,
   output logic                          rsp_error,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [afe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_wdata
);
   import afe_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type seq_result;
   logic       item_done;
   logic       out_free;
   logic       step;
   logic       accept;

   afe_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   afe_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item      (item_ff),
      .load      (accept),
      .step      (step),
      .result    (seq_result),
      .item_done (item_done)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !(step && item_done);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_in.func         = req_func;
         item_in.payload_size = req_payload_size;
         item_in.frame_id     = req_frame_id;
         item_in.options      = req_options;
         item_in.data_byte    = req_data_byte;
         item_valid_in        = 1'b1;
      end else if (step && item_done) begin
         item_valid_in = 1'b0;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_in       = seq_result;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_run_last   = rsp_ff.run_last;
   assign rsp_frame_done = rsp_ff.frame_done;
   assign rsp_error      = rsp_ff.error;

endmodule

[dv/tb_api_tx_frame_encoder_unit.sv]
// Self-checking testbench for the API transmit frame encoder: directed table plus random frames.
`timescale 1ns / 1ps

module tb_api_tx_frame_encoder_unit;
   import afe_pkg::*;

   localparam int          RESET_CYCLES  = 11;
   localparam int          PHASES        = 6;
   localparam int          PHASE_ITEMS   = 38;
   localparam int          HOLD_PHASE    = 0;
   localparam int          BIG_PHASE     = 3;
   localparam int          LONG_HOLD     = 400;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          END_WAIT      = 32;
   localparam int          QUIET_LIMIT   = 4000;
   localparam int          DIRECTED_ROWS = 23;
   localparam logic [CSR_IDX_W-1:0] UNUSED_CSR = 3'd7;

   // first line byte of a start with reset settings, and a rejected payload byte
   localparam result_type DELIM_BYTE = {8'h7E, 1'b0, 1'b0, 1'b0};
   localparam result_type ERR_BYTE   = {ZERO_BYTE, 1'b1, 1'b0, 1'b1};
   localparam result_type NO_PIN     = '0;

   typedef struct packed {
      item_type   it;
      logic       pinned;
      result_type pin;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_func;
   logic [7:0]           req_payload_size;
   logic [7:0]           req_frame_id;
   logic [7:0]           req_options;
   logic [7:0]           req_data_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_run_last;
   logic                 rsp_frame_done;
   logic                 rsp_error;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_wdata;

   // encoder shadow: settings and open-frame state
   cfg_type              line_cfg;
   logic                 enc_open;
   logic [7:0]           enc_left;
   logic [7:0]           enc_sum;

   result_type           item_bytes[$];
   result_type           pending_bytes[$];
   directed_row_type     directed_rows [DIRECTED_ROWS];

   int unsigned          items_sent;
   int unsigned          mismatch_count;
   int unsigned          sink_hold_cycles;
   bit                   src_calm;
   bit                   sink_calm;

   api_tx_frame_encoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_payload_size (req_payload_size),
      .req_frame_id     (req_frame_id),
      .req_options      (req_options),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_error        (rsp_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- encoder shadow

   function automatic bit is_special(logic [7:0] b);
      return b == line_cfg.delimiter_byte || b == line_cfg.escape_byte ||
             b == line_cfg.xon_byte || b == line_cfg.xoff_byte;
   endfunction

   task automatic emit(logic [7:0] b, logic done, logic err);
      result_type r;
      r.out_byte   = b;
      r.run_last   = 1'b0;
      r.frame_done = done;
      r.error      = err;
      item_bytes.push_back(r);
   endtask

   task automatic emit_escaped(logic [7:0] b, logic done);
      if (is_special(b)) begin
         emit(line_cfg.escape_byte, 1'b0, 1'b0);
         emit(b ^ line_cfg.xor_mask, done, 1'b0);
      end else begin
         emit(b, done, 1'b0);
      end
   endtask

   task automatic emit_summed(logic [7:0] b);
      emit_escaped(b, 1'b0);
      enc_sum = enc_sum + b;
   endtask

   task automatic emit_checksum();
      emit_escaped(SUM_BASE - enc_sum, 1'b1);
      enc_open = 1'b0;
      enc_left = '0;
      enc_sum  = '0;
   endtask

   task automatic encode_item(item_type it);
      logic [7:0] len;
      result_type r;
      item_bytes.delete();
      if (it.func == FUNC_START) begin
         len = (it.payload_size > MAX_SIZE) ? MAX_SIZE : it.payload_size;
         enc_sum = '0;
         emit(line_cfg.delimiter_byte, 1'b0, 1'b0);
         emit(ZERO_BYTE, 1'b0, 1'b0);
         emit_escaped(len + LEN_EXTRA, 1'b0);
         emit_summed(line_cfg.request_type);
         emit_summed(it.frame_id);
         for (int i = 7; i >= 0; i--)
            emit_summed(line_cfg.dest_address[i*8 +: 8]);
         emit_summed(it.options);
         enc_left = len;
         enc_open = 1'b1;
         if (enc_left == 0)
            emit_checksum();
      end else if (!enc_open) begin
         emit(ZERO_BYTE, 1'b0, 1'b1);
      end else begin
         emit_summed(it.data_byte);
         enc_left = enc_left - 8'd1;
         if (enc_left == 0)
            emit_checksum();
      end
      r = item_bytes[item_bytes.size()-1];
      r.run_last = 1'b1;
      item_bytes[item_bytes.size()-1] = r;
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic [7:0] pick_line_byte();
      case ($urandom_range(0, 7))
         0:       return line_cfg.delimiter_byte;
         1:       return line_cfg.escape_byte;
         2:       return line_cfg.xon_byte;
         3:       return line_cfg.xoff_byte;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic item_type noisy_item(logic f);
      item_type r;
      r.func         = f;
      r.payload_size = 8'($urandom_range(0, 255));
      r.frame_id     = 8'($urandom_range(0, 255));
      r.options      = 8'($urandom_range(0, 255));
      r.data_byte    = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // A pinned row replaces the first expected byte with the typed-in value.
   task automatic send_item(item_type it, logic pinned, result_type pin);
      int unsigned gap;
      gap = src_calm ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= it.func;
      req_payload_size <= it.payload_size;
      req_frame_id     <= it.frame_id;
      req_options      <= it.options;
      req_data_byte    <= it.data_byte;
      do @(posedge clock); while (req_stall);
      encode_item(it);
      if (pinned)
         item_bytes[0] = pin;
      foreach (item_bytes[i])
         pending_bytes.push_back(item_bytes[i]);
      items_sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEST_ADDRESS: line_cfg.dest_address   = data;
         CSR_DELIMITER:    line_cfg.delimiter_byte = data[7:0];
         CSR_ESCAPE:       line_cfg.escape_byte    = data[7:0];
         CSR_XON:          line_cfg.xon_byte       = data[7:0];
         CSR_XOFF:         line_cfg.xoff_byte      = data[7:0];
         CSR_XOR_MASK:     line_cfg.xor_mask       = data[7:0];
         CSR_REQUEST_TYPE: line_cfg.request_type   = data[7:0];
         default: ;
      endcase
   endtask

   task automatic settle_line();
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- line side

   initial begin : line_sink
      int unsigned hold;
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (sink_hold_cycles != 0) begin
            hold = sink_hold_cycles;
            sink_hold_cycles = 0;
         end else begin
            hold = sink_calm ? 0 : $urandom_range(0, 10);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : line_check
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_byte, rsp_run_last, rsp_frame_done, rsp_error};
         if (pending_bytes.size() == 0) begin
            $display("%0t: line byte with nothing expected: byte %02h last %b done %b err %b",
                     $time, got.out_byte, got.run_last, got.frame_done, got.error);
            mismatch_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (got !== want) begin
               $display("%0t: expected byte %02h last %b done %b err %b, got %02h %b %b %b",
                        $time, want.out_byte, want.run_last, want.frame_done, want.error,
                        got.out_byte, got.run_last, got.frame_done, got.error);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb_api_tx_frame_encoder_unit: errors");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      item_type    it;
      cfg_type     next_cfg;
      logic [63:0] junk;
      logic [7:0]  frame_len;
      logic [7:0]  clamped_len;
      logic [7:0]  body_len;
      logic [7:0]  fill;
      int unsigned kind;
      int unsigned phase_end;
      bit          hold_done;
      bit          big_pending;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_START;
      req_payload_size = '0;
      req_frame_id     = '0;
      req_options      = '0;
      req_data_byte    = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_DEST_ADDRESS;
      csr_wdata        = '0;
      mismatch_count   = 0;
      items_sent       = 0;
      sink_hold_cycles = 0;
      src_calm         = 1'b0;
      sink_calm        = 1'b0;
      hold_done        = 1'b0;
      line_cfg         = {64'd0, 8'h7E, 8'h7D, 8'h11, 8'h13, 8'h20, 8'h00};
      enc_open         = 1'b0;
      enc_left         = '0;
      enc_sum          = '0;

      // func, size, frame id, options, data byte, pinned, pinned first byte
      directed_rows = '{
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'h00, 1'b1, ERR_BYTE},   // data, no frame
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'hFF, 1'b1, ERR_BYTE},
         {FUNC_START, 8'd0,   8'h00, 8'h00, 8'h00, 1'b1, DELIM_BYTE}, // empty payload
         {FUNC_DATA,  8'hFF,  8'hFF, 8'hFF, 8'h5A, 1'b1, ERR_BYTE},
         {FUNC_START, 8'd3,   8'h7E, 8'h7D, 8'h00, 1'b1, DELIM_BYTE},
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'h11, 1'b0, NO_PIN},
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'h13, 1'b0, NO_PIN},
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
         {FUNC_START, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1, DELIM_BYTE}, // clamped size
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'hFF, 1'b0, NO_PIN},
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'h7E, 1'b0, NO_PIN},
         {FUNC_START, 8'd6,   8'h11, 8'h13, 8'h00, 1'b0, NO_PIN},     // abandons open frame
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'h7D, 1'b0, NO_PIN},
         {FUNC_START, 8'd2,   8'h00, 8'h20, 8'h00, 1'b0, NO_PIN},
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'h80, 1'b0, NO_PIN},
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'h7F, 1'b0, NO_PIN},
         {FUNC_START, 8'd115, 8'h01, 8'h02, 8'h00, 1'b0, NO_PIN},     // length hits delimiter
         {FUNC_START, 8'd114, 8'h03, 8'h04, 8'h00, 1'b0, NO_PIN},     // length hits escape
         {FUNC_START, 8'd8,   8'h05, 8'h06, 8'h00, 1'b0, NO_PIN},
         {FUNC_START, 8'd1,   8'hAA, 8'h55, 8'h00, 1'b0, NO_PIN},
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'h01, 1'b0, NO_PIN},
         {FUNC_DATA,  8'd0,   8'h00, 8'h00, 8'h02, 1'b1, ERR_BYTE},
         {FUNC_START, 8'd244, 8'h00, 8'h00, 8'h00, 1'b1, DELIM_BYTE}  // left open
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         src_calm  = ($urandom_range(0, 3) == 0);
         sink_calm = ($urandom_range(0, 3) == 0);
         send_item(directed_rows[i].it, directed_rows[i].pinned, directed_rows[i].pin);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // registers change only with the line drained
         req_valid <= 1'b0;
         settle_line();

         junk = {$urandom, $urandom};
         case (phase)
            0: next_cfg = {64'h0013_A200_7E7D_1113, 8'h7E, 8'h7D, 8'h11, 8'h13, 8'h20, 8'h00};
            1: next_cfg = '0;
            2: next_cfg = '1;
            3: next_cfg = {{$urandom, $urandom}, 8'h7E, 8'h7D, 8'h11, 8'h13, 8'h20, 8'h10};
            default: begin
               next_cfg.dest_address   = {$urandom, $urandom};
               next_cfg.delimiter_byte = 8'($urandom_range(0, 255));
               next_cfg.escape_byte    = 8'($urandom_range(0, 255));
               next_cfg.xon_byte       = 8'($urandom_range(0, 255));
               next_cfg.xoff_byte      = 8'($urandom_range(0, 255));
               next_cfg.xor_mask       = 8'($urandom_range(0, 255));
               next_cfg.request_type   = 8'($urandom_range(0, 255));
               if (phase == 4)
                  next_cfg.xoff_byte = next_cfg.escape_byte;
            end
         endcase

         write_reg(CSR_DEST_ADDRESS, next_cfg.dest_address);
         write_reg(CSR_DELIMITER,    {junk[63:8], next_cfg.delimiter_byte});
         write_reg(CSR_ESCAPE,       {junk[63:8], next_cfg.escape_byte});
         write_reg(CSR_XON,          {junk[63:8], next_cfg.xon_byte});
         write_reg(CSR_XOFF,         {junk[63:8], next_cfg.xoff_byte});
         write_reg(CSR_XOR_MASK,     {junk[63:8], next_cfg.xor_mask});
         write_reg(CSR_REQUEST_TYPE, {junk[63:8], next_cfg.request_type});
         if (phase >= 4)
            write_reg(UNUSED_CSR, junk);
         csr_valid <= 1'b0;

         phase_end   = items_sent + PHASE_ITEMS;
         big_pending = (phase == BIG_PHASE);
         while (items_sent < phase_end) begin
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            if (phase == HOLD_PHASE && !hold_done) begin
               // hold the line off while the encoder is kept busy
               sink_hold_cycles = LONG_HOLD;
               src_calm  = 1'b1;
               hold_done = 1'b1;
            end
            kind = $urandom_range(0, 15);
            if (kind == 0 && !big_pending) begin
               // stray payload byte, rejected unless a frame was left open
               it = noisy_item(FUNC_DATA);
               it.data_byte = pick_line_byte();
               send_item(it, 1'b0, NO_PIN);
            end else begin
               if (big_pending)
                  frame_len = MAX_SIZE;
               else if (kind < 11)
                  frame_len = 8'($urandom_range(0, 8));
               else if (kind < 14)
                  frame_len = 8'($urandom_range(9, 40));
               else
                  frame_len = 8'($urandom_range(MAX_SIZE, 255));
               clamped_len = (frame_len > MAX_SIZE) ? MAX_SIZE : frame_len;
               body_len = clamped_len;
               if (!big_pending && kind >= 14)
                  body_len = 8'($urandom_range(0, 6));
               else if (kind == 13)
                  body_len = 8'($urandom_range(0, clamped_len));
               big_pending = 1'b0;

               it = noisy_item(FUNC_START);
               it.payload_size = frame_len;
               if (kind[0])
                  it.frame_id = pick_line_byte();
               if (kind[1])
                  it.options = pick_line_byte();
               send_item(it, 1'b0, NO_PIN);

               for (int k = 0; k < body_len; k++) begin
                  it = noisy_item(FUNC_DATA);
                  fill = pick_line_byte();
                  // steer the checksum onto a special byte now and then
                  if (k == body_len - 1 && body_len == clamped_len &&
                      $urandom_range(0, 3) == 0)
                     fill = SUM_BASE - pick_line_byte() - enc_sum;
                  it.data_byte = fill;
                  send_item(it, 1'b0, NO_PIN);
               end
            end
         end
      end

      req_valid <= 1'b0;
      settle_line();
      repeat (END_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_api_tx_frame_encoder_unit: clean");
      else
         $display("tb_api_tx_frame_encoder_unit: errors");
      $finish;
   end

endmodule

[sim.f]
rtl/afe_pkg.sv
rtl/afe_cfg.sv
rtl/afe_seq.sv
rtl/api_tx_frame_encoder_unit.sv
dv/tb_api_tx_frame_encoder_unit.sv
